FILE: hdl/prefix_acl_group_match_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prefix ACL group match core
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_ACL_GROUP_MATCH_CORE_DEFINES_SVH
`define PREFIX_ACL_GROUP_MATCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define PACL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PACL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pacl_pkg.sv
// ----------------------------------------------------------------------------
// Prefix ACL package
// Request, response and mask entry types, op, kind and status codes, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package pacl_pkg;

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_LOOKUP = 3'd2;
	localparam logic [2:0] OP_FIND   = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [1:0] KIND_V4  = 2'd0;
	localparam logic [1:0] KIND_V6  = 2'd1;
	localparam logic [1:0] KIND_ALL = 2'd2;

	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_DUP         = 3'd1;
	localparam logic [2:0] STAT_GROUPS_FULL = 3'd2;
	localparam logic [2:0] STAT_MASKS_FULL  = 3'd3;
	localparam logic [2:0] STAT_NO_GROUP    = 3'd4;
	localparam logic [2:0] STAT_MISS        = 3'd5;

	localparam logic [7:0] V4_MAX_LEN = 8'd32;
	localparam logic [7:0] V6_MAX_LEN = 8'd128;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] tag;
		logic [1:0]  mask_kind;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_len;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] match_tag;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] prefix_high;
		logic [63:0] prefix_low;
		logic [7:0]  len;
		logic [15:0] group_tag;
	} mask_entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/prefix_acl_group_match_core.sv
// A lookup scans the stored masks and stops at the first hit; create group and find tag scan
// the stored groups; other ops do no scan.
// One request at a time; the scan reads one memory entry per cycle through a registered read port.
// A new request is taken the cycle after the previous one moves to the response register.
// Reset (arst_n low) empties the table at once: group, mask and per-group counts go to zero.
// ----------------------------------------------------------------------------
// Prefix ACL group match core
// Group tag and mask memories scanned in order; first matching mask gives the tag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prefix_acl_group_match_core_defines.svh"

module prefix_acl_group_match_core #(
	parameter int GROUP_SLOTS     = 32,
	parameter int MASK_SLOTS      = 128,
	parameter int MASKS_PER_GROUP = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pacl_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output pacl_pkg::rsp_t   rsp
);

	localparam int GIW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
	localparam int GCW = $clog2(GROUP_SLOTS + 1);
	localparam int MIW = (MASK_SLOTS > 1) ? $clog2(MASK_SLOTS) : 1;
	localparam int MCW = $clog2(MASK_SLOTS + 1);
	localparam int NCW = $clog2(MASKS_PER_GROUP + 1);
	localparam int SW  = (GCW > MCW) ? GCW : MCW;

	pacl_pkg::state_t state_q, state_d;
	pacl_pkg::req_t   req_q;
	pacl_pkg::rsp_t   res_q, res_d, rsp_q;
	logic             rsp_valid_q;

	logic [GCW-1:0] grp_cnt_q;
	logic [MCW-1:0] msk_cnt_q;
	logic [NCW-1:0] newest_cnt_q;
	logic [15:0]    newest_tag_q;

	logic [SW-1:0] iss_q;
	logic [SW-1:0] scan_cnt;
	logic          rd_vld_s1;
	logic          last_s1;

	logic [15:0]           grp_mem [GROUP_SLOTS];
	pacl_pkg::mask_entry_t msk_mem [MASK_SLOTS];
	logic [15:0]           grp_rd_s1;
	pacl_pkg::mask_entry_t msk_rd_s1;

	logic msk_hit;
	logic hit_s1;
	logic fin;
	logic issue;
	logic rsp_free;
	logic rsp_load;
	logic grp_we;
	logic msk_we;
	logic clr;

	pacl_mask_cmp u_cmp (
		.entry     (msk_rd_s1),
		.kind      (req_q.mask_kind),
		.addr_high (req_q.addr_high),
		.addr_low  (req_q.addr_low),
		.hit       (msk_hit)
	);

	// Lookup walks the mask memory, create and find walk the group memory.
	always_comb begin
		priority if (req_q.op == pacl_pkg::OP_LOOKUP) begin
			scan_cnt = SW'(msk_cnt_q);
		end else if (req_q.op == pacl_pkg::OP_CREATE || req_q.op == pacl_pkg::OP_FIND) begin
			scan_cnt = SW'(grp_cnt_q);
		end else begin
			scan_cnt = '0;
		end
	end

	always_comb begin
		hit_s1 = rd_vld_s1 &&
			((req_q.op == pacl_pkg::OP_LOOKUP) ? msk_hit : (grp_rd_s1 == req_q.tag));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pacl_pkg::S_IDLE: begin
				if (req_valid) state_d = pacl_pkg::S_EXEC;
			end
			pacl_pkg::S_EXEC: begin
				if (fin) state_d = pacl_pkg::S_DONE;
			end
			pacl_pkg::S_DONE: begin
				if (rsp_free) state_d = pacl_pkg::S_IDLE;
			end
			default: state_d = pacl_pkg::S_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		req_stall = (state_q != pacl_pkg::S_IDLE);
		rsp_free  = !rsp_valid_q || !rsp_stall;
		rsp_load  = (state_q == pacl_pkg::S_DONE) && rsp_free;
		fin       = (state_q == pacl_pkg::S_EXEC) &&
			((scan_cnt == '0) || (rd_vld_s1 && (hit_s1 || last_s1)));
		issue     = (state_q == pacl_pkg::S_EXEC) && !fin && (iss_q < scan_cnt);
	end

	// Result and table updates at the end of a request. Writes never overlap a scan,
	// since only one request is in flight.
	always_comb begin
		res_d  = '{status: pacl_pkg::STAT_OK, match_tag: 16'd0};
		grp_we = 1'b0;
		msk_we = 1'b0;
		clr    = 1'b0;
		if (fin) begin
			unique case (req_q.op)
				pacl_pkg::OP_CREATE: begin
					priority if (hit_s1) begin
						res_d.status = pacl_pkg::STAT_DUP;
					end else if (grp_cnt_q >= GCW'(GROUP_SLOTS)) begin
						res_d.status = pacl_pkg::STAT_GROUPS_FULL;
					end else begin
						grp_we = 1'b1;
					end
				end
				pacl_pkg::OP_ADD: begin
					priority if (grp_cnt_q == '0) begin
						res_d.status = pacl_pkg::STAT_NO_GROUP;
					end else if (newest_cnt_q >= NCW'(MASKS_PER_GROUP) ||
						msk_cnt_q >= MCW'(MASK_SLOTS)) begin
						res_d.status = pacl_pkg::STAT_MASKS_FULL;
					end else begin
						msk_we = 1'b1;
					end
				end
				pacl_pkg::OP_LOOKUP: begin
					if (hit_s1) res_d.match_tag = msk_rd_s1.group_tag;
					else res_d.status = pacl_pkg::STAT_MISS;
				end
				pacl_pkg::OP_FIND: begin
					if (hit_s1) res_d.match_tag = req_q.tag;
					else res_d.status = pacl_pkg::STAT_MISS;
				end
				pacl_pkg::OP_CLEAR: begin
					clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pacl_pkg::S_IDLE;
			rsp_valid_q  <= 1'b0;
			grp_cnt_q    <= '0;
			msk_cnt_q    <= '0;
			newest_cnt_q <= '0;
			iss_q        <= '0;
			rd_vld_s1    <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			rd_vld_s1   <= issue;
			if (state_q == pacl_pkg::S_IDLE) iss_q <= '0;
			else if (issue) iss_q <= iss_q + SW'(1);
			if (clr) begin
				grp_cnt_q    <= '0;
				msk_cnt_q    <= '0;
				newest_cnt_q <= '0;
			end else if (grp_we) begin
				grp_cnt_q    <= grp_cnt_q + GCW'(1);
				newest_cnt_q <= '0;
			end else if (msk_we) begin
				msk_cnt_q    <= msk_cnt_q + MCW'(1);
				newest_cnt_q <= newest_cnt_q + NCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pacl_pkg::S_IDLE && req_valid) req_q <= req;
		if (issue) last_s1 <= ((iss_q + SW'(1)) == scan_cnt);
		if (grp_we) newest_tag_q <= req_q.tag;
		if (fin) res_q <= res_d;
		if (rsp_load) rsp_q <= res_q;
	end

	// Group tag memory
	always_ff @(posedge clk) begin
		if (grp_we) grp_mem[grp_cnt_q[GIW-1:0]] <= req_q.tag;
		if (issue) grp_rd_s1 <= grp_mem[iss_q[GIW-1:0]];
	end

	// Mask memory
	always_ff @(posedge clk) begin
		if (msk_we) begin
			msk_mem[msk_cnt_q[MIW-1:0]] <= '{
				kind:        req_q.mask_kind,
				prefix_high: req_q.addr_high,
				prefix_low:  req_q.addr_low,
				len:         req_q.prefix_len,
				group_tag:   newest_tag_q
			};
		end
		if (issue) msk_rd_s1 <= msk_mem[iss_q[MIW-1:0]];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PACL_ASSERT_NOW(a_grp_cnt_range, 1'b1, grp_cnt_q <= GCW'(GROUP_SLOTS), "group count over depth")
	`PACL_ASSERT_NOW(a_msk_cnt_range, 1'b1, msk_cnt_q <= MCW'(MASK_SLOTS), "mask count over depth")
	`PACL_ASSERT_NOW(a_no_write_in_scan, issue, !grp_we && !msk_we, "table write during scan")
	`PACL_ASSERT_NOW(a_read_in_exec, rd_vld_s1, state_q == pacl_pkg::S_EXEC, "read data outside scan")
	`PACL_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_q == pacl_pkg::S_EXEC, "accept without exec")

endmodule

`default_nettype wire

FILE: hdl/pacl_mask_cmp.sv
// ----------------------------------------------------------------------------
// Prefix ACL mask compare
// Checks one stored mask entry against a lookup address under its prefix length.
// ----------------------------------------------------------------------------
`default_nettype none

module pacl_mask_cmp (
	input  pacl_pkg::mask_entry_t entry,
	input  logic [1:0]            kind,
	input  logic [63:0]           addr_high,
	input  logic [63:0]           addr_low,
	output logic                  hit
);

	logic [31:0] m4;
	logic [63:0] mh;
	logic [63:0] ml;

	// Bit b of a mask is set when its distance from the first address bit is below len.
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			m4[b] = 8'(31 - b) < entry.len;
		end
		for (int b = 0; b < 64; b++) begin
			mh[b] = 8'(63 - b) < entry.len;
			ml[b] = 8'(127 - b) < entry.len;
		end
	end

	always_comb begin
		priority if (entry.kind == pacl_pkg::KIND_ALL) begin
			hit = 1'b1;
		end else if (entry.kind != kind) begin
			hit = 1'b0;
		end else if (entry.kind == pacl_pkg::KIND_V4) begin
			hit = (entry.len <= pacl_pkg::V4_MAX_LEN) &&
				(((entry.prefix_low[31:0] ^ addr_low[31:0]) & m4) == 32'd0);
		end else if (entry.kind == pacl_pkg::KIND_V6) begin
			hit = (entry.len <= pacl_pkg::V6_MAX_LEN) &&
				(((entry.prefix_high ^ addr_high) & mh) == 64'd0) &&
				(((entry.prefix_low ^ addr_low) & ml) == 64'd0);
		end else begin
			hit = 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: dv/pacl_match_checker.sv
// ----------------------------------------------------------------------------
// Prefix ACL match checker
// Watches the request and response channels of the group match core, keeps
// its own copy of the group and mask tables, predicts the response to every
// accepted request and compares each accepted response with the oldest one.
// ----------------------------------------------------------------------------
module pacl_match_checker
	import pacl_pkg::*;
#(
	parameter int GROUP_SLOTS     = 32,
	parameter int MASK_SLOTS      = 128,
	parameter int MASKS_PER_GROUP = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] group_tags [GROUP_SLOTS];
	mask_entry_t acl_masks [MASK_SLOTS];
	int unsigned group_total;
	int unsigned mask_total;
	int unsigned newest_masks;

	rsp_t expected_rsp [$];
	rsp_t oldest;
	int   fail_total = 0;

	function automatic logic [63:0] lead_ones(int unsigned n);
		if (n == 0)
			return 64'd0;
		if (n >= 64)
			return '1;
		return ~64'd0 << (64 - n);
	endfunction

	function automatic bit tag_known(logic [15:0] tag);
		for (int unsigned g = 0; g < group_total; g++)
			if (group_tags[g] == tag)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit mask_hits(mask_entry_t m, logic [1:0] kind,
			logic [63:0] hi, logic [63:0] lo);
		int unsigned len;
		logic [63:0] keep_hi;
		logic [63:0] keep_lo;
		len = m.len;
		if (m.kind == KIND_ALL)
			return 1'b1;
		if (m.kind != kind)
			return 1'b0;
		if (m.kind == KIND_V4) begin
			if (m.len > V4_MAX_LEN)
				return 1'b0;
			keep_lo = lead_ones(len) >> 32;
			return ((m.prefix_low ^ lo) & keep_lo) == 64'd0;
		end
		if (m.kind == KIND_V6) begin
			if (m.len > V6_MAX_LEN)
				return 1'b0;
			keep_hi = lead_ones(len > 64 ? 64 : len);
			keep_lo = lead_ones(len > 64 ? len - 64 : 0);
			return ((m.prefix_high ^ hi) & keep_hi) == 64'd0 &&
				((m.prefix_low ^ lo) & keep_lo) == 64'd0;
		end
		return 1'b0;
	endfunction

	// Apply one request to the table copy and return the response it earns.
	function automatic rsp_t acl_outcome(req_t r);
		rsp_t        o;
		logic [63:0] lo;
		o.status    = STAT_OK;
		o.match_tag = 16'd0;
		case (r.op)
			OP_CREATE: begin
				if (tag_known(r.tag)) begin
					o.status = STAT_DUP;
				end else if (group_total >= GROUP_SLOTS) begin
					o.status = STAT_GROUPS_FULL;
				end else begin
					group_tags[group_total] = r.tag;
					group_total++;
					newest_masks = 0;
				end
			end
			OP_ADD: begin
				if (group_total == 0) begin
					o.status = STAT_NO_GROUP;
				end else if (newest_masks >= MASKS_PER_GROUP || mask_total >= MASK_SLOTS) begin
					o.status = STAT_MASKS_FULL;
				end else begin
					acl_masks[mask_total].kind        = r.mask_kind;
					acl_masks[mask_total].prefix_high = r.addr_high;
					acl_masks[mask_total].prefix_low  = r.addr_low;
					acl_masks[mask_total].len         = r.prefix_len;
					acl_masks[mask_total].group_tag   = group_tags[group_total - 1];
					mask_total++;
					newest_masks++;
				end
			end
			OP_LOOKUP: begin
				o.status = STAT_MISS;
				lo = r.addr_low;
				if (r.mask_kind == KIND_V4)
					lo = {32'd0, lo[31:0]};
				for (int unsigned i = 0; i < mask_total; i++) begin
					if (mask_hits(acl_masks[i], r.mask_kind, r.addr_high, lo)) begin
						o.status    = STAT_OK;
						o.match_tag = acl_masks[i].group_tag;
						break;
					end
				end
			end
			OP_FIND: begin
				if (tag_known(r.tag))
					o.match_tag = r.tag;
				else
					o.status = STAT_MISS;
			end
			OP_CLEAR: begin
				group_total  = 0;
				mask_total   = 0;
				newest_masks = 0;
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_total  = 0;
			mask_total   = 0;
			newest_masks = 0;
			expected_rsp.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with none expected, actual status %0d tag %h",
						$time, rsp.status, rsp.match_tag);
					fail_total++;
				end else begin
					oldest = expected_rsp.pop_front();
					if (rsp.status !== oldest.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, oldest.status, rsp.status);
						fail_total++;
					end
					if (rsp.match_tag !== oldest.match_tag) begin
						$display("%0t: match_tag mismatch, expected %h, actual %h",
							$time, oldest.match_tag, rsp.match_tag);
						fail_total++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(acl_outcome(req));
			outstanding <= expected_rsp.size();
			mismatches  <= fail_total;
		end
	end

endmodule

FILE: dv/tb_prefix_acl_group_match_core.sv
// ----------------------------------------------------------------------------
// Prefix ACL group match core testbench
// Drives directed and random request streams (sessions of create, add,
// lookup and find, table fills and noise) with random idling on both sides;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_prefix_acl_group_match_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pacl_pkg::*;

	localparam int GROUPS    = 32;
	localparam int MASKS     = 128;
	localparam int PER_GROUP = 256;
	localparam int ITEM_GOAL = 550;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;

	// Rough picture of table contents, used only to aim stimulus.
	logic [15:0] created_tags [$];
	mask_entry_t stored_masks [$];
	int          items_sent = 0;
	bit          calm = 1'b0;

	prefix_acl_group_match_core #(
		.GROUP_SLOTS    (GROUPS),
		.MASK_SLOTS     (MASKS),
		.MASKS_PER_GROUP(PER_GROUP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	pacl_match_checker #(
		.GROUP_SLOTS    (GROUPS),
		.MASK_SLOTS     (MASKS),
		.MASKS_PER_GROUP(PER_GROUP)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] top_ones(int unsigned n);
		if (n == 0)
			return 64'd0;
		if (n >= 64)
			return '1;
		return ~64'd0 << (64 - n);
	endfunction

	// Send one request: idle for a random gap, then hold it until accepted.
	task automatic issue(logic [2:0] op, logic [15:0] tag, logic [1:0] kind,
			logic [63:0] hi, logic [63:0] lo, logic [7:0] len);
		req_t        r;
		mask_entry_t m;
		int          gap;
		bit          seen;
		r.op         = op;
		r.tag        = tag;
		r.mask_kind  = kind;
		r.addr_high  = hi;
		r.addr_low   = lo;
		r.prefix_len = len;
		seen = 1'b0;
		case (op)
			OP_CREATE: begin
				foreach (created_tags[i])
					if (created_tags[i] == tag)
						seen = 1'b1;
				if (!seen && created_tags.size() < GROUPS)
					created_tags.push_back(tag);
			end
			OP_ADD: begin
				if (created_tags.size() > 0 && stored_masks.size() < MASKS) begin
					m.kind        = kind;
					m.prefix_high = hi;
					m.prefix_low  = lo;
					m.len         = len;
					m.group_tag   = created_tags[created_tags.size() - 1];
					stored_masks.push_back(m);
				end
			end
			OP_CLEAR: begin
				created_tags.delete();
				stored_masks.delete();
			end
			default: ;
		endcase
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Hold off until every response in flight has come back.
	task automatic drain_pause();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Look up an address close to a stored mask: inside its prefix, or one bit off.
	task automatic probe_stored();
		mask_entry_t m;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] keep_hi;
		logic [63:0] keep_lo;
		logic [1:0]  kind;
		int unsigned n;
		hi = rand64();
		lo = rand64();
		if (stored_masks.size() == 0) begin
			issue(OP_LOOKUP, 16'($urandom), 2'($urandom_range(0, 1)), hi, lo,
				8'($urandom));
			return;
		end
		m    = stored_masks[$urandom_range(0, stored_masks.size() - 1)];
		kind = m.kind;
		if (m.kind == KIND_V4) begin
			n       = m.len > 32 ? 32 : m.len;
			keep_lo = top_ones(n) >> 32;
			lo      = (lo & ~keep_lo) | (m.prefix_low & keep_lo);
		end else if (m.kind == KIND_V6) begin
			n       = m.len > 128 ? 128 : m.len;
			keep_hi = top_ones(n > 64 ? 64 : n);
			keep_lo = top_ones(n > 64 ? n - 64 : 0);
			hi      = (hi & ~keep_hi) | (m.prefix_high & keep_hi);
			lo      = (lo & ~keep_lo) | (m.prefix_low & keep_lo);
		end else begin
			kind = 2'($urandom_range(0, 3));
		end
		if ($urandom_range(0, 4) == 0) begin
			if (kind == KIND_V4)
				lo[$urandom_range(0, 31)] ^= 1'b1;
			else if ($urandom_range(0, 1) == 0)
				hi[$urandom_range(0, 63)] ^= 1'b1;
			else
				lo[$urandom_range(0, 63)] ^= 1'b1;
		end
		issue(OP_LOOKUP, 16'($urandom), kind, hi, lo, 8'($urandom));
	endtask

	task automatic add_random_mask(bit allow_all);
		logic [1:0] kind;
		logic [7:0] len;
		int         pick;
		pick = $urandom_range(0, 19);
		if (pick < 9)
			kind = KIND_V4;
		else if (pick < 18)
			kind = KIND_V6;
		else if (pick == 18 && allow_all)
			kind = KIND_ALL;
		else
			kind = 2'd3;
		if ($urandom_range(0, 7) == 0)
			len = 8'($urandom);
		else if (kind == KIND_V4)
			len = 8'($urandom_range(0, 32));
		else
			len = 8'($urandom_range(0, 128));
		issue(OP_ADD, 16'($urandom), kind, rand64(), rand64(), len);
	endtask

	// A short life of the table: groups, masks, then lookups and finds.
	task automatic run_session();
		int          groups;
		int          masks;
		logic [15:0] tag;
		if ($urandom_range(0, 2) == 0)
			issue(OP_CLEAR, 16'($urandom), 2'($urandom), rand64(), rand64(), 8'($urandom));
		groups = $urandom_range(1, 3);
		for (int g = 0; g < groups; g++) begin
			if (created_tags.size() > 0 && $urandom_range(0, 5) == 0)
				tag = created_tags[$urandom_range(0, created_tags.size() - 1)];
			else if ($urandom_range(0, 3) == 0)
				tag = 16'($urandom_range(0, 3));
			else
				tag = 16'($urandom);
			issue(OP_CREATE, tag, 2'($urandom), rand64(), rand64(), 8'($urandom));
			masks = $urandom_range(0, 4);
			for (int k = 0; k < masks; k++)
				add_random_mask(1'b1);
		end
		repeat ($urandom_range(2, 6))
			probe_stored();
		repeat ($urandom_range(1, 2)) begin
			if (created_tags.size() > 0 && $urandom_range(0, 1) == 0)
				tag = created_tags[$urandom_range(0, created_tags.size() - 1)];
			else
				tag = 16'($urandom);
			issue(OP_FIND, tag, 2'($urandom), rand64(), rand64(), 8'($urandom));
		end
	endtask

	// Fill both stores past their limits, then scan the full mask store.
	task automatic run_fill();
		logic [15:0] base;
		base = 16'($urandom);
		issue(OP_CLEAR, 16'($urandom), 2'($urandom), rand64(), rand64(), 8'($urandom));
		for (int g = 0; g <= GROUPS; g++) begin
			issue(OP_CREATE, base + 16'(g), 2'($urandom), rand64(), rand64(),
				8'($urandom));
			if (g == 4)
				issue(OP_CREATE, base + 16'd2, 2'($urandom), rand64(), rand64(),
					8'($urandom));
		end
		repeat (MASKS + 2)
			add_random_mask(1'b0);
		repeat (6)
			probe_stored();
		repeat (2)
			issue(OP_LOOKUP, 16'($urandom), 2'($urandom_range(0, 1)), rand64(), rand64(),
				8'($urandom));
	endtask

	task automatic run_noise();
		issue(3'($urandom_range(0, 7)), 16'($urandom), 2'($urandom), rand64(), rand64(),
			8'($urandom));
	endtask

	task automatic run_directed();
		issue(OP_ADD, 16'h0, KIND_V4, 64'h0, 64'h0000_0000_C0A8_0100, 8'd24);
		issue(OP_LOOKUP, 16'h0, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_FIND, 16'h0000, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_CREATE, 16'h0000, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_CREATE, 16'h0000, KIND_V6, '1, '1, 8'hff);
		issue(OP_ADD, 16'h0, KIND_V4, '1, 64'hFFFF_FFFF_C0A8_0100, 8'd24);
		issue(OP_ADD, 16'h0, KIND_V4, 64'h0, 64'h0000_0000_0A00_0000, 8'd33);
		issue(OP_ADD, 16'h0, KIND_V6, 64'h2001_0DB8_0000_0000, 64'h0, 8'd129);
		issue(OP_ADD, 16'h0, 2'd3, '1, '1, 8'd0);
		issue(OP_CREATE, 16'hFFFF, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_ADD, 16'h0, KIND_V6, 64'h2001_0DB8_1234_5678, 64'hDEAD_BEEF_0000_0001, 8'd128);
		issue(OP_ADD, 16'h0, KIND_V6, 64'h2001_0DB8_0000_0000, 64'h0, 8'd64);
		issue(OP_ADD, 16'h0, KIND_V6, 64'hFE80_0000_0000_0000, 64'h8000_0000_0000_0000, 8'd65);
		issue(OP_LOOKUP, 16'h0, KIND_V4, '1, 64'hFFFF_FFFF_C0A8_01FF, 8'd0);
		issue(OP_LOOKUP, 16'h0, KIND_V4, 64'h0, 64'h0000_0000_0A00_0000, 8'd0);
		issue(OP_LOOKUP, 16'h0, KIND_V6, 64'h2001_0DB8_1234_5678, 64'hDEAD_BEEF_0000_0001, 8'd0);
		issue(OP_LOOKUP, 16'h0, KIND_V6, 64'h2001_0DB8_FFFF_FFFF, rand64(), 8'd0);
		issue(OP_LOOKUP, 16'h0, KIND_V6, 64'hFE80_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 8'd0);
		issue(OP_LOOKUP, 16'h0, 2'd3, '1, '1, 8'd0);
		issue(OP_ADD, 16'h0, KIND_ALL, rand64(), rand64(), 8'hff);
		issue(OP_LOOKUP, 16'h0, KIND_ALL, rand64(), rand64(), 8'd0);
		issue(OP_LOOKUP, 16'h0, 2'd3, rand64(), rand64(), 8'd0);
		issue(OP_FIND, 16'hFFFF, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_CLEAR, 16'h0, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_FIND, 16'hFFFF, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_CREATE, 16'h8001, KIND_V4, 64'h0, 64'h0, 8'd0);
		issue(OP_ADD, 16'h0, KIND_V4, 64'h0, rand64(), 8'd0);
		issue(OP_LOOKUP, 16'h0, KIND_V4, rand64(), rand64(), 8'd0);
		issue(3'd5, 16'hFFFF, 2'd3, '1, '1, 8'hff);
		issue(3'd7, 16'($urandom), 2'($urandom), rand64(), rand64(), 8'($urandom));
	endtask

	// Response side: stall a random number of cycles, then take one response.
	initial begin
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			int hold;
			hold = calm ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	initial begin
		int  guard;
		bit  filled;
		req_valid <= 1'b0;
		req       <= '0;
		arst_n    <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n    <= 1'b1;
		@(posedge clk);
		run_directed();
		drain_pause();
		filled = 1'b0;
		while (items_sent < ITEM_GOAL) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 7) == 0)
				drain_pause();
			if ((!filled && items_sent > ITEM_GOAL / 3) || $urandom_range(0, 39) == 0) begin
				filled = 1'b1;
				run_fill();
			end else begin
				run_session();
			end
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3))
					run_noise();
		end
		calm       = 1'b0;
		req_valid <= 1'b0;
		guard      = 0;
		@(posedge clk);
		while (outstanding != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (140) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pacl_pkg.sv
hdl/pacl_mask_cmp.sv
hdl/prefix_acl_group_match_core.sv
dv/pacl_match_checker.sv
dv/tb_prefix_acl_group_match_core.sv
